>>> hw/rtl/pfta_pkg.sv
// Package with the shared types and constants of the page frame table allocator.
`timescale 1ns / 1ps
package pfta_pkg;

    localparam int FRAMES_DEFAULT = 1024;

    localparam logic [1:0] REQ_KALLOC   = 2'd0;
    localparam logic [1:0] REQ_KFREE    = 2'd1;
    localparam logic [1:0] REQ_FAULT    = 2'd2;
    localparam logic [1:0] REQ_FREE_OWN = 2'd3;

    localparam logic [1:0] FAULT_INVALID = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOMEM   = 3'd1;
    localparam logic [2:0] ST_BADKIND = 3'd2;
    localparam logic [2:0] ST_NOAS    = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [0:0] REG_FRAMES_IN_USE = 1'd0;
    localparam logic [0:0] REG_BASE_PAGE     = 1'd1;

    localparam logic [10:0] FRAMES_IN_USE_RESET = 11'd1024;
    localparam logic [19:0] BASE_PAGE_RESET     = 20'd256;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] page_count;
        logic [19:0] page_number;
        logic [7:0]  owner_id;
        logic [19:0] virtual_page;
        logic [1:0]  fault_kind;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] frame_page;
        logic        fresh_frame;
    } t_res;

    typedef struct packed {
        logic        used;
        logic        kernel;
        logic [7:0]  owner;
        logic [19:0] vpage;
        logic [10:0] run_len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> hw/rtl/pfta_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pfta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/page_frame_table_allocator_core.sv
// Top level of the first-fit page frame table allocator.
// Operation: a kernel allocation, page fault or free-owner request scans the table (n
// managed frames); an allocation then writes each of its frames in turn and finishes.
// A kernel free reads the start entry and then releases each frame of its chunk.
// One request is in flight at a time; throughput is set by the single read port of the
// frame table memory.
// Reset: a clearing pass writes every one of the FRAMES entries, one per cycle, with busy
// high; the result strobe cannot be stalled by the receiver.
`timescale 1ns / 1ps
module page_frame_table_allocator_core #(
    parameter int FRAMES = pfta_pkg::FRAMES_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pfta_pkg::t_req i_req,
    output logic           o_done,
    output pfta_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    // Index width addresses the table, count width holds the frame count itself.
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FRD  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_rv, n_rv;
    logic [IW-1:0]   r_didx, n_didx;
    pfta_pkg::t_req  r_req, n_req;
    logic            r_found, n_found;
    logic [IW-1:0]   r_start, n_start;
    logic [CW-1:0]   r_run, n_run;
    logic            r_match, n_match;
    logic [IW-1:0]   r_midx, n_midx;
    logic            r_ffound, n_ffound;
    logic [IW-1:0]   r_fidx, n_fidx;
    logic [CW-1:0]   r_wptr, n_wptr;
    logic [CW-1:0]   r_wend, n_wend;
    logic            r_walloc, n_walloc;
    logic            r_done, n_done;
    pfta_pkg::t_res  r_res, n_res;
    logic [10:0]     r_fiu;
    logic [19:0]     r_base;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    pfta_pkg::t_entry              ram_wdata;
    logic [IW-1:0]                 ram_raddr;
    logic [pfta_pkg::ENTRY_W-1:0]  ram_rdata;
    pfta_pkg::t_entry              rd_entry;

    logic [CW-1:0]  n_frames;
    logic [19:0]    free_idx;
    logic           free_bad;
    logic [20:0]    free_end;
    logic           cfg_wr;

    pfta_ram #(
        .WIDTH (pfta_pkg::ENTRY_W),
        .DEPTH (FRAMES),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = pfta_pkg::t_entry'(ram_rdata);

    // A frame count above the table size acts as the table size.
    assign n_frames = (32'(r_fiu) > 32'(FRAMES)) ? CW'(FRAMES) : CW'(r_fiu);

    // A kernel free is checked against the managed range before any table access.
    assign free_idx = i_req.page_number - r_base;
    assign free_bad = (i_req.page_number < r_base) || ({1'b0, free_idx} >= 21'(n_frames));
    assign free_end = 21'(r_wptr) + 21'(rd_entry.run_len);

    // The configuration port never waits; writes land in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            pfta_pkg::REG_FRAMES_IN_USE: prdata = {21'd0, r_fiu};
            pfta_pkg::REG_BASE_PAGE:     prdata = {12'd0, r_base};
            default:                     prdata = 32'd0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_rv     = 1'b0;
        n_didx   = r_didx;
        n_req    = r_req;
        n_found  = r_found;
        n_start  = r_start;
        n_run    = r_run;
        n_match  = r_match;
        n_midx   = r_midx;
        n_ffound = r_ffound;
        n_fidx   = r_fidx;
        n_wptr   = r_wptr;
        n_wend   = r_wend;
        n_walloc = r_walloc;
        n_done   = 1'b0;
        n_res    = r_res;

        ram_we    = 1'b0;
        ram_waddr = r_ptr[IW-1:0];
        ram_wdata = '0;
        ram_raddr = r_ptr[IW-1:0];

        case (r_state)
            S_CLR: begin
                // Post-reset sweep: every entry becomes free with all fields zero.
                ram_we    = 1'b1;
                ram_waddr = r_ptr[IW-1:0];
                n_ptr     = r_ptr + CW'(1);
                if (r_ptr == CW'(FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_req    = i_req;
                    n_ptr    = '0;
                    n_found  = 1'b0;
                    n_run    = '0;
                    n_match  = 1'b0;
                    n_ffound = 1'b0;
                    n_res    = '0;
                    case (i_req.req_type)
                        pfta_pkg::REQ_KALLOC: begin
                            if (i_req.page_count == 11'd0) begin
                                n_res.status = pfta_pkg::ST_NOMEM;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        pfta_pkg::REQ_KFREE: begin
                            if (free_bad) begin
                                n_res.status = pfta_pkg::ST_IGNORED;
                                n_done       = 1'b1;
                            end else begin
                                // Fetch the start entry to learn the chunk length.
                                ram_raddr = free_idx[IW-1:0];
                                n_wptr    = CW'(free_idx);
                                n_state   = S_FRD;
                            end
                        end
                        pfta_pkg::REQ_FAULT: begin
                            if (i_req.fault_kind == pfta_pkg::FAULT_INVALID) begin
                                n_res.status = pfta_pkg::ST_BADKIND;
                                n_done       = 1'b1;
                            end else if (i_req.owner_id == 8'd0) begin
                                n_res.status = pfta_pkg::ST_NOAS;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            if (i_req.owner_id == 8'd0) begin
                                n_res.status = pfta_pkg::ST_IGNORED;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one read per cycle; the entry comes back in the cycle after its read.
                if (r_ptr < n_frames) begin
                    ram_raddr = r_ptr[IW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_rv      = 1'b1;
                    n_didx    = r_ptr[IW-1:0];
                end

                if (r_rv) begin
                    case (r_req.req_type)
                        pfta_pkg::REQ_KALLOC: begin
                            if (!r_found) begin
                                if (!rd_entry.used) begin
                                    if (r_run == '0) begin
                                        n_start = r_didx;
                                    end
                                    n_run = r_run + CW'(1);
                                    if (32'(r_run) + 32'd1 == 32'(r_req.page_count)) begin
                                        n_found = 1'b1;
                                    end
                                end else begin
                                    n_run = '0;
                                end
                            end
                        end
                        pfta_pkg::REQ_FAULT: begin
                            if (!r_match && rd_entry.used && !rd_entry.kernel &&
                                rd_entry.owner == r_req.owner_id &&
                                rd_entry.vpage == r_req.virtual_page) begin
                                n_match = 1'b1;
                                n_midx  = r_didx;
                            end
                            if (!r_ffound && !rd_entry.used) begin
                                n_ffound = 1'b1;
                                n_fidx   = r_didx;
                            end
                        end
                        pfta_pkg::REQ_FREE_OWN: begin
                            // Reads run one entry ahead, so this write never meets a read.
                            if (rd_entry.used && !rd_entry.kernel &&
                                rd_entry.owner == r_req.owner_id) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_didx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (r_ptr >= n_frames && !r_rv) begin
                    n_state = S_IDLE;
                    case (r_req.req_type)
                        pfta_pkg::REQ_KALLOC: begin
                            if (r_found) begin
                                n_wptr   = CW'(r_start);
                                n_wend   = CW'(32'(r_start) + 32'(r_req.page_count));
                                n_walloc = 1'b1;
                                n_state  = S_WR;
                            end else begin
                                n_res.status = pfta_pkg::ST_NOMEM;
                                n_done       = 1'b1;
                            end
                        end
                        pfta_pkg::REQ_FAULT: begin
                            n_done = 1'b1;
                            if (r_match) begin
                                n_res.frame_page = r_base + 20'(r_midx);
                            end else if (r_ffound) begin
                                ram_we              = 1'b1;
                                ram_waddr           = r_fidx;
                                ram_wdata.used      = 1'b1;
                                ram_wdata.owner     = r_req.owner_id;
                                ram_wdata.vpage     = r_req.virtual_page;
                                ram_wdata.run_len   = 11'd1;
                                n_res.frame_page    = r_base + 20'(r_fidx);
                                n_res.fresh_frame   = 1'b1;
                            end else begin
                                n_res.status = pfta_pkg::ST_NOMEM;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_FRD: begin
                if (rd_entry.run_len == 11'd0) begin
                    n_res.status = pfta_pkg::ST_IGNORED;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    // The release stops at the end of the managed frames.
                    n_wend   = (free_end > 21'(n_frames)) ? n_frames : CW'(free_end);
                    n_walloc = 1'b0;
                    n_state  = S_WR;
                end
            end

            S_WR: begin
                if (r_wptr < r_wend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wptr[IW-1:0];
                    if (r_walloc) begin
                        ram_wdata.used   = 1'b1;
                        ram_wdata.kernel = 1'b1;
                        if (r_wptr[IW-1:0] == r_start) begin
                            ram_wdata.run_len = r_req.page_count;
                        end
                    end
                    n_wptr = r_wptr + CW'(1);
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_walloc) begin
                        n_res.frame_page = r_base + 20'(r_start);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ptr   <= '0;
            r_rv    <= 1'b0;
            r_done  <= 1'b0;
            r_fiu   <= pfta_pkg::FRAMES_IN_USE_RESET;
            r_base  <= pfta_pkg::BASE_PAGE_RESET;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_rv    <= n_rv;
            r_done  <= n_done;
            if (cfg_wr) begin
                case (paddr[2])
                    pfta_pkg::REG_FRAMES_IN_USE: r_fiu  <= pwdata[10:0];
                    pfta_pkg::REG_BASE_PAGE:     r_base <= pwdata[19:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx   <= n_didx;
        r_req    <= n_req;
        r_found  <= n_found;
        r_start  <= n_start;
        r_run    <= n_run;
        r_match  <= n_match;
        r_midx   <= n_midx;
        r_ffound <= n_ffound;
        r_fidx   <= n_fidx;
        r_wptr   <= n_wptr;
        r_wend   <= n_wend;
        r_walloc <= n_walloc;
        r_res    <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
